// ===== hdl/lda_pkg.sv =====
// Shared constants, types and count helpers for the topic sampler.
package lda_pkg;

    localparam int TOPICS  = 16;
    localparam int TOPIC_W = 4;
    localparam int KUSE_W  = 5;
    localparam int VOCAB_W = 12;
    localparam int VUSE_W  = 13;
    localparam int DOC_W   = 10;
    localparam int ENT_W   = 14;
    localparam int TOKEN_W = 16;
    localparam int CNT_W   = 32;
    localparam int PRIOR_W = 32;
    localparam int DRAW_W  = 32;
    localparam int QUO_W   = 32;
    localparam int DIV_W   = 50;
    localparam int SUM_W   = 64;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } lda_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } lda_div_rsp_t;

    // count minus tokens, floor at zero
    function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                                 input logic [TOKEN_W-1:0] n);
        logic [CNT_W-1:0] nx;
        nx = {{(CNT_W-TOKEN_W){1'b0}}, n};
        return (a > nx) ? a - nx : '0;
    endfunction

    // count plus tokens, ceiling at all ones
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [TOKEN_W-1:0] n);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W+1-TOKEN_W){1'b0}}, n};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

endpackage

// ===== hdl/lda_if.sv =====
// Item and result channel interfaces.
interface lda_item_if import lda_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [ENT_W-1:0]   entry_index;
    logic [DOC_W-1:0]   doc_index;
    logic [VOCAB_W-1:0] word_index;
    logic [TOKEN_W-1:0] token_count;
    logic [TOPIC_W-1:0] init_topic;
    logic [DRAW_W-1:0]  uniform_draw;

    modport source (output valid, kind, entry_index, doc_index, word_index, token_count,
                    init_topic, uniform_draw, input ready);
    modport sink (input valid, kind, entry_index, doc_index, word_index, token_count,
                  init_topic, uniform_draw, output ready);
endinterface

interface lda_result_if import lda_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TOPIC_W-1:0] old_topic;
    logic [TOPIC_W-1:0] new_topic;

    modport source (output valid, old_topic, new_topic, input ready);
    modport sink (input valid, old_topic, new_topic, output ready);
endinterface

// ===== hdl/lda_div.sv =====
// Bit-serial restoring divider giving a saturated Q0.32 quotient.
module lda_div import lda_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  lda_div_req_t req,
    output lda_div_rsp_t rsp
);

    logic [DIV_W:0]   rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DIV_W:0]   rem_sh;
    logic             ge;

    // one quotient bit per cycle
    assign rem_sh = {rem_reg[DIV_W-1:0], 1'b0};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg <= '0;
            den_reg <= req.den;
            rem_reg <= {1'b0, req.num};
            if (req.den == '0)
            begin
                quo_reg  <= '0;
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else if (req.num >= req.den)
            begin
                quo_reg  <= '1;
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                quo_reg  <= '0;
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sh - {1'b0, den_reg} : rem_sh;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(QUO_W-1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== hdl/lda_gibbs_topic_sampler.sv =====
// Top level of the collapsed Gibbs topic sampler.
// Usage: items arrive on a valid/ready channel, one result (old_topic,
// new_topic) per item leaves on a valid/ready channel. Priors, topic count
// and vocabulary size are set through an APB port, by the user only while
// the block is idle (the block does not enforce this). After reset the
// count memories are swept to zero, one address per cycle; no item is
// taken during the sweep (register writes still are). A load item (kind 0)
// passes S_OLD, S_ARD, S_ADD, S_OUT; a resample item (kind 1) adds S_SUB,
// S_LRD, S_LDIV, S_LWAIT, S_LMUL and S_LACC for each of K topics in use,
// S_THR1, S_THR2 and 1 to K scan steps; results go valid on return to idle.
// Each topic waits on the two 32-step bit-serial dividers that form both
// weight factors, run side by side; a topic whose factors both saturate or
// see a zero divisor skips those steps. One item is worked on at a time;
// the result sits in an output register, so the next item is accepted
// while it waits. A stalled receiver only holds the block at the end of
// the following item.
module lda_gibbs_topic_sampler import lda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    lda_item_if.sink           items,
    lda_result_if.source       results,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_BETA  = 2'd1;
    localparam logic [1:0] REG_TOPIC = 2'd2;
    localparam logic [1:0] REG_VOCAB = 2'd3;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_OLD   = 4'd2;
    localparam logic [3:0] S_SUB   = 4'd3;
    localparam logic [3:0] S_LRD   = 4'd4;
    localparam logic [3:0] S_LDIV  = 4'd5;
    localparam logic [3:0] S_LWAIT = 4'd6;
    localparam logic [3:0] S_LMUL  = 4'd7;
    localparam logic [3:0] S_LACC  = 4'd8;
    localparam logic [3:0] S_THR1  = 4'd9;
    localparam logic [3:0] S_THR2  = 4'd10;
    localparam logic [3:0] S_SCAN  = 4'd11;
    localparam logic [3:0] S_ARD   = 4'd12;
    localparam logic [3:0] S_ADD   = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    localparam int WTC_AW = TOPIC_W + VOCAB_W;
    localparam int DTC_AW = DOC_W + TOPIC_W;

    // configuration registers
    logic [PRIOR_W-1:0] alpha_reg;
    logic [PRIOR_W-1:0] beta_reg;
    logic [KUSE_W-1:0]  topics_reg;
    logic [VUSE_W-1:0]  vocab_reg;

    // control
    logic [3:0]         state_reg;
    logic [15:0]        clr_reg;
    logic [TOPIC_W-1:0] k_reg;

    // item fields
    logic               kind_reg;
    logic [ENT_W-1:0]   ent_reg;
    logic [DOC_W-1:0]   doc_reg;
    logic [VOCAB_W-1:0] word_reg;
    logic [TOKEN_W-1:0] n_reg;
    logic [TOPIC_W-1:0] init_reg;
    logic [DRAW_W-1:0]  u_reg;
    logic [TOPIC_W-1:0] old_reg;
    logic [TOPIC_W-1:0] new_reg;

    // arithmetic
    logic [CNT_W-1:0]   dtot_reg;
    logic [44:0]        vbeta_reg;
    logic [36:0]        kalpha_reg;
    logic [DIV_W-1:0]   dden_reg;
    logic [63:0]        prod_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   cum_reg [TOPICS];
    logic [63:0]        phi_reg;
    logic [63:0]        plo_reg;
    logic [SUM_W-1:0]   thr_reg;

    // result
    logic               rv_reg;
    logic [TOPIC_W-1:0] rold_reg;
    logic [TOPIC_W-1:0] rnew_reg;

    // count stores
    logic [TOPIC_W-1:0] toe_mem  [2**ENT_W];
    logic [CNT_W-1:0]   dtc_mem  [2**DTC_AW];
    logic [CNT_W-1:0]   wtc_mem  [2**WTC_AW];
    logic [CNT_W-1:0]   dtot_mem [2**DOC_W];
    logic [CNT_W-1:0]   tt_reg   [TOPICS];

    logic [TOPIC_W-1:0] toe_q;
    logic [CNT_W-1:0]   dtc_q, wtc_q, dtot_q;

    logic               toe_we, dtc_we, wtc_we, dtot_we;
    logic [ENT_W-1:0]   toe_wa, toe_ra;
    logic [TOPIC_W-1:0] toe_wd;
    logic [DTC_AW-1:0]  dtc_wa, dtc_ra;
    logic [WTC_AW-1:0]  wtc_wa, wtc_ra;
    logic [DOC_W-1:0]   dtot_wa, dtot_ra;
    logic [CNT_W-1:0]   dtc_wd, wtc_wd, dtot_wd;

    logic [TOPIC_W-1:0] tt_idx;
    logic [CNT_W-1:0]   tt_rd;
    logic [KUSE_W-1:0]  k_use;
    logic [TOPIC_W-1:0] k_last;
    logic [VUSE_W-1:0]  v_use;
    logic               in_xfer;
    logic               out_free;
    logic               cfg_wr;

    lda_div_req_t       dw_req, dd_req;
    lda_div_rsp_t       dw_rsp, dd_rsp;

    // effective topic and vocabulary counts
    always_comb
    begin
        if (topics_reg == '0)
            k_use = KUSE_W'(1);
        else if (topics_reg > KUSE_W'(TOPICS))
            k_use = KUSE_W'(TOPICS);
        else
            k_use = topics_reg;
        k_last = TOPIC_W'(k_use - KUSE_W'(1));
        v_use  = (vocab_reg == '0) ? VUSE_W'(1) : vocab_reg;
    end

    assign in_xfer  = items.valid && items.ready;
    assign out_free = !rv_reg || results.ready;
    assign items.ready = (state_reg == S_IDLE);
    assign results.valid     = rv_reg;
    assign results.old_topic = rold_reg;
    assign results.new_topic = rnew_reg;

    // APB register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_ALPHA: prdata = alpha_reg;
            REG_BETA:  prdata = beta_reg;
            REG_TOPIC: prdata = {{(32-KUSE_W){1'b0}}, topics_reg};
            REG_VOCAB: prdata = {{(32-VUSE_W){1'b0}}, vocab_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= 32'd6554;
            beta_reg   <= 32'd6554;
            topics_reg <= KUSE_W'(16);
            vocab_reg  <= VUSE_W'(4096);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ALPHA: alpha_reg  <= pwdata;
                REG_BETA:  beta_reg   <= pwdata;
                REG_TOPIC: topics_reg <= pwdata[KUSE_W-1:0];
                REG_VOCAB: vocab_reg  <= pwdata[VUSE_W-1:0];
                default:   ;
            endcase
        end
    end

    // topic total read select
    always_comb
    begin
        case (state_reg)
            S_SUB:   tt_idx = old_reg;
            S_ADD:   tt_idx = new_reg;
            default: tt_idx = k_reg;
        endcase
    end
    assign tt_rd = tt_reg[tt_idx];

    // memory addresses and write data
    always_comb
    begin
        toe_ra  = items.entry_index;
        dtot_ra = items.doc_index;
        case (state_reg)
            S_OLD:   begin dtc_ra = {doc_reg, toe_q};   wtc_ra = {toe_q, word_reg};   end
            S_ARD:   begin dtc_ra = {doc_reg, new_reg}; wtc_ra = {new_reg, word_reg}; end
            default: begin dtc_ra = {doc_reg, k_reg};   wtc_ra = {k_reg, word_reg};   end
        endcase

        toe_we  = 1'b0;
        dtc_we  = 1'b0;
        wtc_we  = 1'b0;
        dtot_we = 1'b0;
        toe_wa  = ent_reg;
        toe_wd  = new_reg;
        dtc_wa  = {doc_reg, old_reg};
        wtc_wa  = {old_reg, word_reg};
        dtot_wa = doc_reg;
        dtc_wd  = sat_sub(dtc_q, n_reg);
        wtc_wd  = sat_sub(wtc_q, n_reg);
        dtot_wd = sat_sub(dtot_reg, n_reg);
        case (state_reg)
            S_CLEAR:
            begin
                toe_we  = 1'b1;
                dtc_we  = 1'b1;
                wtc_we  = 1'b1;
                dtot_we = 1'b1;
                toe_wa  = clr_reg[ENT_W-1:0];
                dtc_wa  = clr_reg[DTC_AW-1:0];
                wtc_wa  = clr_reg[WTC_AW-1:0];
                dtot_wa = clr_reg[DOC_W-1:0];
                toe_wd  = '0;
                dtc_wd  = '0;
                wtc_wd  = '0;
                dtot_wd = '0;
            end
            S_SUB:
            begin
                dtc_we  = 1'b1;
                wtc_we  = 1'b1;
                dtot_we = 1'b1;
            end
            S_ADD:
            begin
                toe_we  = 1'b1;
                dtc_we  = 1'b1;
                wtc_we  = 1'b1;
                dtot_we = 1'b1;
                dtc_wa  = {doc_reg, new_reg};
                wtc_wa  = {new_reg, word_reg};
                dtc_wd  = sat_add(dtc_q, n_reg);
                wtc_wd  = sat_add(wtc_q, n_reg);
                dtot_wd = sat_add(dtot_reg, n_reg);
            end
            default: ;
        endcase
    end

    // synchronous memories
    always_ff @(posedge clk)
    begin
        if (toe_we)
            toe_mem[toe_wa] <= toe_wd;
        toe_q <= toe_mem[toe_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dtc_we)
            dtc_mem[dtc_wa] <= dtc_wd;
        dtc_q <= dtc_mem[dtc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (wtc_we)
            wtc_mem[wtc_wa] <= wtc_wd;
        wtc_q <= wtc_mem[wtc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dtot_we)
            dtot_mem[dtot_wa] <= dtot_wd;
        dtot_q <= dtot_mem[dtot_ra];
    end

    // per-topic totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOPICS; i++)
                tt_reg[i] <= '0;
        end
        else if (state_reg == S_SUB && kind_reg)
            tt_reg[tt_idx] <= sat_sub(tt_rd, n_reg);
        else if (state_reg == S_ADD)
            tt_reg[tt_idx] <= sat_add(tt_rd, n_reg);
    end

    // weight factor dividers
    always_comb
    begin
        dw_req.start = (state_reg == S_LDIV);
        dw_req.num   = {2'b0, wtc_q, 16'b0} + {{(DIV_W-PRIOR_W){1'b0}}, beta_reg};
        dw_req.den   = {2'b0, tt_rd, 16'b0} + {{(DIV_W-45){1'b0}}, vbeta_reg};
        dd_req.start = (state_reg == S_LDIV);
        dd_req.num   = {2'b0, dtc_q, 16'b0} + {{(DIV_W-PRIOR_W){1'b0}}, alpha_reg};
        dd_req.den   = dden_reg;
    end

    lda_div u_div_word
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dw_req),
        .rsp   (dw_rsp)
    );

    lda_div u_div_doc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dd_req),
        .rsp   (dd_rsp)
    );

    // item sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            k_reg     <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            // result slot: load wins over a drained slot
            if (state_reg == S_OUT && out_free)
                rv_reg <= 1'b1;
            else if (results.ready)
                rv_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 16'd1;
                    if (clr_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_xfer)
                        state_reg <= S_OLD;
                end
                S_OLD:
                begin
                    k_reg     <= '0;
                    state_reg <= kind_reg ? S_SUB : S_ARD;
                end
                S_SUB:   state_reg <= S_LRD;
                S_LRD:   state_reg <= S_LDIV;
                S_LDIV:  state_reg <= S_LWAIT;
                S_LWAIT:
                begin
                    // either factor may finish early on saturation or a zero divisor
                    if (!dw_rsp.busy && !dd_rsp.busy)
                        state_reg <= S_LMUL;
                end
                S_LMUL:  state_reg <= S_LACC;
                S_LACC:
                begin
                    if (k_reg == k_last)
                        state_reg <= S_THR1;
                    else
                    begin
                        k_reg     <= k_reg + TOPIC_W'(1);
                        state_reg <= S_LRD;
                    end
                end
                S_THR1:  state_reg <= S_THR2;
                S_THR2:
                begin
                    k_reg     <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (cum_reg[k_reg] > thr_reg || k_reg == k_last)
                        state_reg <= S_ARD;
                    else
                        k_reg <= k_reg + TOPIC_W'(1);
                end
                S_ARD:   state_reg <= S_ADD;
                S_ADD:   state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                kind_reg <= items.kind;
                ent_reg  <= items.entry_index;
                doc_reg  <= items.doc_index;
                word_reg <= items.word_index;
                n_reg    <= items.token_count;
                init_reg <= items.init_topic;
                u_reg    <= items.uniform_draw;
            end
            S_OLD:
            begin
                old_reg  <= toe_q;
                new_reg  <= init_reg;
                dtot_reg <= dtot_q;
                sum_reg  <= '0;
            end
            S_SUB:
            begin
                dtot_reg   <= sat_sub(dtot_reg, n_reg);
                vbeta_reg  <= v_use * beta_reg;
                kalpha_reg <= k_use * alpha_reg;
            end
            S_LRD:   dden_reg <= {2'b0, dtot_reg, 16'b0}
                                 + {{(DIV_W-37){1'b0}}, kalpha_reg};
            S_LMUL:  prod_reg <= dw_rsp.quo * dd_rsp.quo;
            S_LACC:
            begin
                sum_reg        <= sum_reg + {32'b0, prod_reg[63:32]};
                cum_reg[k_reg] <= sum_reg + {32'b0, prod_reg[63:32]};
            end
            S_THR1:
            begin
                phi_reg <= u_reg * sum_reg[63:32];
                plo_reg <= u_reg * sum_reg[31:0];
            end
            S_THR2:  thr_reg <= phi_reg + {32'b0, plo_reg[63:32]};
            S_SCAN:  new_reg <= k_reg;
            S_OUT:
            begin
                if (out_free)
                begin
                    rold_reg <= old_reg;
                    rnew_reg <= new_reg;
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    // a topic pass only starts once both dividers are free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LDIV |-> !dw_rsp.busy && !dd_rsp.busy)
        else $error("divider started while busy");

    // cumulative weight never drops during accumulation
    a_sum_mono: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LACC |=> sum_reg >= $past(sum_reg))
        else $error("weight sum decreased");

    // a new result is only loaded when the output slot is free
    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && rv_reg && !results.ready |=> state_reg == S_OUT)
        else $error("result overwritten while stalled");
`endif

endmodule
